// ===== rtl/mass_spring_chain_derivative_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef MASS_SPRING_CHAIN_DERIVATIVE_TOP_MACROS_SVH
`define MASS_SPRING_CHAIN_DERIVATIVE_TOP_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define MSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/msc_pkg.sv =====
// ----------------------------------------------------------------------------
// Mass-spring chain package
// Shared widths, register indexes, the saturation and floor helpers and cell types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package msc_pkg;
    localparam int Particles = 4;
    localparam int IdxW = 2;
    localparam int CfgIdxW = 3;

    localparam logic [CfgIdxW-1:0] CFG_GRAVITY = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DRAG = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_REST = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_STIFF = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_MASK = 3'd4;

    typedef logic signed [31:0] t_word;
    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
    } t_vec;

    // Signed value of up to 96 bits saturated to 32 bits.
    function automatic t_word sat32(input logic signed [95:0] v);
        t_word r;
        if (v > 96'sh7FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -96'sh80000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor(v / 2^16) as an arithmetic shift.
    function automatic logic signed [95:0] floor16(input logic signed [95:0] v);
        return v >>> 16;
    endfunction
endpackage

// ===== rtl/mass_spring_chain_derivative_top.sv =====
// ----------------------------------------------------------------------------
// Mass-spring chain derivative
// Loads particles into a chain of cells, then evaluates drag, gravity and
// chain spring forces and emits one derivative item per particle.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake
// in      | input     | i_valid / o_ready
// out     | output    | o_valid / i_ready
// cfg     | input     | i_cfg_we, no wait
// After a non-final item the input stays ready for the next one. A final item
// starts an evaluation: each spring passes through the bit-serial square root
// and then three serial divides, and a zero-length spring skips the divides.
// PARTICLES results follow, then an align state realigns the chain. The
// input is not ready until then; a stalled output holds its item. Reset is
// synchronous.
`timescale 1ns / 1ps
module mass_spring_chain_derivative_top import msc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IdxW-1:0]   i_particle_index,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    input  logic              i_last_particle,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [IdxW-1:0]   o_out_index,
    output logic signed [31:0] o_dpos_x,
    output logic signed [31:0] o_dpos_y,
    output logic signed [31:0] o_dpos_z,
    output logic signed [31:0] o_accel_x,
    output logic signed [31:0] o_accel_y,
    output logic signed [31:0] o_accel_z,
    output logic              o_last_result,
    input  logic              i_cfg_we,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data
);
    typedef enum logic [3:0] {
        S_LOAD, S_BASE, S_SHIFT_B, S_DELTA, S_SQSUM, S_SQGO, S_SQRT, S_MAG,
        S_DIV, S_FORCE, S_NEXT, S_OUT, S_ALIGN
    } t_state;

    t_state r_state;
    t_word r_gravity;
    logic [30:0] r_drag, r_rest, r_stiff;
    logic [3:0] r_mask;
    logic [IdxW-1:0] r_cnt;
    logic [1:0] r_comp;
    t_vec r_d;
    logic [65:0] r_sum;
    logic [32:0] r_len;
    logic signed [47:0] r_mag;
    logic signed [95:0] r_f;

    t_vec pos [Particles];
    t_vec vel [Particles];
    t_vec frc [Particles];
    logic shift;
    logic frc_we [Particles];
    t_vec frc_new [Particles];
    t_vec load_pos, load_vel;
    logic accept;
    logic sq_start, sq_done, dv_start, dv_done;
    logic [32:0] sq_root;
    logic signed [48:0] dv_q;
    t_word d_comp;
    t_vec base;

    assign accept = i_valid && o_ready;
    assign o_ready = (r_state == S_LOAD);
    assign load_pos = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
    assign load_vel = '{x: i_vel_x, y: i_vel_y, z: i_vel_z};
    assign shift = (r_state == S_SHIFT_B) || (r_state == S_NEXT)
                   || (r_state == S_OUT && i_ready) || (r_state == S_ALIGN);
    assign sq_start = (r_state == S_SQGO);
    assign dv_start = (r_state == S_MAG) || (r_state == S_FORCE && r_comp != 2'd3);

    always_comb begin
        case (r_comp)
            2'd0: d_comp = r_d.x;
            2'd1: d_comp = r_d.y;
            default: d_comp = r_d.z;
        endcase
        base.x = sat32(-floor16(96'(signed'({1'b0, r_drag}) * vel[0].x)));
        base.y = sat32(96'(r_gravity)
                 - floor16(96'(signed'({1'b0, r_drag}) * vel[0].y)));
        base.z = sat32(-floor16(96'(signed'({1'b0, r_drag}) * vel[0].z)));
    end

    always_comb begin
        for (int k = 0; k < Particles; k++) begin
            frc_we[k] = 1'b0;
            frc_new[k] = frc[k];
        end
        if (r_state == S_BASE) begin
            frc_we[0] = 1'b1;
            frc_new[0] = base;
        end
        if (r_state == S_FORCE && r_comp != 2'd0) begin
            frc_we[0] = 1'b1;
            frc_we[1] = 1'b1;
            case (r_comp)
                2'd1: begin
                    frc_new[0].x = sat32(96'(frc[0].x) + r_f);
                    frc_new[1].x = sat32(96'(frc[1].x) - r_f);
                end
                2'd2: begin
                    frc_new[0].y = sat32(96'(frc[0].y) + r_f);
                    frc_new[1].y = sat32(96'(frc[1].y) - r_f);
                end
                default: begin
                    frc_new[0].z = sat32(96'(frc[0].z) + r_f);
                    frc_new[1].z = sat32(96'(frc[1].z) - r_f);
                end
            endcase
        end
    end

    for (genvar g = 0; g < Particles; g++) begin : g_cell
        msc_cell u_cell (
            .i_clk      (i_clk),
            .i_load     (accept && i_particle_index == IdxW'(g)),
            .i_load_pos (load_pos),
            .i_load_vel (load_vel),
            .i_shift    (shift),
            .i_pos      (pos[(g + 1) % Particles]),
            .i_vel      (vel[(g + 1) % Particles]),
            .i_frc      (frc[(g + 1) % Particles]),
            .i_frc_we   (frc_we[g]),
            .i_frc_new  (frc_new[g]),
            .o_pos      (pos[g]),
            .o_vel      (vel[g]),
            .o_frc      (frc[g])
        );
    end

    msc_sqrt u_sqrt (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (sq_start),
        .i_val (r_sum), .o_done (sq_done), .o_root (sq_root)
    );

    msc_div u_div (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (dv_start),
        .i_num (d_comp), .i_den (r_len), .o_done (dv_done), .o_quot (dv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_gravity <= -32'sd131072;
            r_drag <= 31'd65536;
            r_rest <= 31'd65536;
            r_stiff <= 31'd65536000;
            r_mask <= 4'd8;
            o_valid <= 1'b0;
            r_cnt <= '0;
            r_comp <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_GRAVITY: r_gravity <= i_cfg_data;
                    CFG_DRAG: r_drag <= i_cfg_data[30:0];
                    CFG_REST: r_rest <= i_cfg_data[30:0];
                    CFG_STIFF: r_stiff <= i_cfg_data[30:0];
                    CFG_MASK: r_mask <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_LOAD: begin
                    if (accept && i_last_particle) begin
                        r_state <= S_BASE;
                        r_cnt <= '0;
                    end
                end
                S_BASE: r_state <= S_SHIFT_B;
                S_SHIFT_B: begin
                    r_cnt <= r_cnt + IdxW'(1);
                    if (r_cnt == IdxW'(Particles - 1)) begin
                        r_state <= S_DELTA;
                        r_cnt <= '0;
                    end else begin
                        r_state <= S_BASE;
                    end
                end
                S_DELTA: begin
                    r_d.x <= sat32(96'(pos[0].x) - 96'(pos[1].x));
                    r_d.y <= sat32(96'(pos[0].y) - 96'(pos[1].y));
                    r_d.z <= sat32(96'(pos[0].z) - 96'(pos[1].z));
                    r_state <= S_SQSUM;
                end
                S_SQSUM: r_state <= S_SQGO;
                S_SQGO: r_state <= S_SQRT;
                S_SQRT: begin
                    if (sq_done) begin
                        r_len <= sq_root;
                        r_state <= (sq_root == '0) ? S_NEXT : S_MAG;
                        r_comp <= '0;
                    end
                end
                S_MAG: r_state <= S_DIV;
                S_DIV: begin
                    if (dv_done) begin
                        r_f <= floor16(-96'(r_mag * signed'(dv_q[17:0])));
                        r_comp <= r_comp + 2'd1;
                        r_state <= S_FORCE;
                    end
                end
                S_FORCE: r_state <= (r_comp == 2'd3) ? S_NEXT : S_DIV;
                S_NEXT: begin
                    r_cnt <= r_cnt + IdxW'(1);
                    if (r_cnt == IdxW'(Particles - 2)) begin
                        r_state <= S_OUT;
                        r_cnt <= '0;
                        o_valid <= 1'b1;
                    end else begin
                        r_state <= S_DELTA;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_cnt <= r_cnt + IdxW'(1);
                        if (r_cnt == IdxW'(Particles - 1)) begin
                            o_valid <= 1'b0;
                            r_state <= S_ALIGN;
                        end
                    end
                end
                S_ALIGN: r_state <= S_LOAD;
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // Square sum is registered from the held delta, spring force magnitude from the root length.
    always_ff @(posedge i_clk) begin
        if (r_state == S_SQSUM) begin
            r_sum <= 66'(r_d.x * r_d.x) + 66'(r_d.y * r_d.y) + 66'(r_d.z * r_d.z);
        end
        if (r_state == S_MAG) begin
            r_mag <= 48'(floor16(96'(signed'({1'b0, r_stiff}))
                     * (96'(signed'({1'b0, r_len})) - 96'(signed'({1'b0, r_rest})))));
        end
    end

    // After the last spring the chain has rotated by PARTICLES-1, so cell 1
    // holds particle 0 when results start.
    always_comb begin
        o_out_index = r_cnt;
        o_dpos_x = vel[1].x;
        o_dpos_y = vel[1].y;
        o_dpos_z = vel[1].z;
        if (r_mask[r_cnt]) begin
            o_accel_x = '0;
            o_accel_y = '0;
            o_accel_z = '0;
        end else begin
            o_accel_x = frc[1].x;
            o_accel_y = frc[1].y;
            o_accel_z = frc[1].z;
        end
        o_last_result = (r_cnt == IdxW'(Particles - 1));
    end
endmodule

// ===== rtl/msc_cell.sv =====
// ----------------------------------------------------------------------------
// Particle cell
// Holds one particle's position, velocity and force and shifts them along the
// chain, so the spring unit always sees the two cells at the head.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msc_cell import msc_pkg::*; (
    input  logic i_clk,
    input  logic i_load,
    input  t_vec i_load_pos,
    input  t_vec i_load_vel,
    input  logic i_shift,
    input  t_vec i_pos,
    input  t_vec i_vel,
    input  t_vec i_frc,
    input  logic i_frc_we,
    input  t_vec i_frc_new,
    output t_vec o_pos,
    output t_vec o_vel,
    output t_vec o_frc
);
    t_vec r_pos, r_vel, r_frc;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pos <= i_pos;
            r_vel <= i_vel;
            r_frc <= i_frc;
        end else begin
            if (i_load) begin
                r_pos <= i_load_pos;
                r_vel <= i_load_vel;
            end
            if (i_frc_we) begin
                r_frc <= i_frc_new;
            end
        end
    end

    assign o_pos = r_pos;
    assign o_vel = r_vel;
    assign o_frc = r_frc;
endmodule

// ===== rtl/msc_sqrt.sv =====
// ----------------------------------------------------------------------------
// Iterative square root
// Restoring integer square root of a 66-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msc_sqrt import msc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [65:0] i_val,
    output logic        o_done,
    output logic [32:0] o_root
);
    logic [65:0] r_rem;
    logic [32:0] r_root;
    logic [65:0] r_val;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [67:0] trial;
    logic [67:0] rem_sh;

    always_comb begin
        rem_sh = {r_rem, r_val[65:64]};
        trial = {33'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem <= '0;
                r_root <= '0;
                r_val <= i_val;
                r_cnt <= 6'd0;
            end else if (r_busy) begin
                r_val <= {r_val[63:0], 2'b00};
                if (rem_sh >= trial) begin
                    r_rem <= 66'(rem_sh - trial);
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem <= rem_sh[65:0];
                    r_root <= {r_root[31:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd32) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_root = r_root;
endmodule

// ===== rtl/msc_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Signed numerator, scaled by 2^16, over an unsigned denominator, truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module msc_div import msc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_word       i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic signed [48:0] o_quot
);
    logic [47:0] r_num;
    logic [32:0] r_den;
    logic [47:0] r_q;
    logic [33:0] r_rem;
    logic        r_neg;
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [33:0] rem_sh;

    assign rem_sh = {r_rem[32:0], r_num[47]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_neg <= i_num[31];
                r_num <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), 16'd0};
                r_den <= i_den;
                r_q <= '0;
                r_rem <= '0;
                r_cnt <= 6'd0;
            end else if (r_busy) begin
                r_num <= {r_num[46:0], 1'b0};
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= 34'(rem_sh - {1'b0, r_den});
                    r_q <= {r_q[46:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q <= {r_q[46:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? -$signed({1'b0, r_q}) : $signed({1'b0, r_q});
endmodule

// ===== rtl/msc_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level's ports for ordering and holding of results, and input ready during results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mass_spring_chain_derivative_top_macros.svh"
module msc_checker import msc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_ready,
    input logic o_valid,
    input logic i_ready,
    input logic [IdxW-1:0] o_out_index,
    input logic o_last_result
);
    `MSC_ASSERT_IMP(a_no_overlap, o_valid, !o_ready, "input ready during results")
    `MSC_ASSERT_IMP(a_last_idx, o_valid && o_last_result, o_out_index == IdxW'(Particles - 1), "last flag on wrong index")
    `MSC_ASSERT_NEXT(a_hold, o_valid && !i_ready, o_valid && $stable(o_out_index), "result dropped while stalled")
    `MSC_ASSERT_NEXT(a_advance, o_valid && i_ready && !o_last_result, o_valid && o_out_index == IdxW'($past(o_out_index) + 1'b1), "result index skipped")
endmodule

bind mass_spring_chain_derivative_top msc_checker u_msc_checker (
    .i_clk (i_clk), .i_rst_n (i_rst_n), .o_ready (o_ready), .o_valid (o_valid),
    .i_ready (i_ready), .o_out_index (o_out_index), .o_last_result (o_last_result)
);

// ===== tb/mass_spring_chain_derivative_top_test.sv =====
// ----------------------------------------------------------------------------
// Mass-spring chain derivative testbench
// Loads particle sets through the input channel and predicts the velocity and
// acceleration of every particle, including saturation and zero-length
// springs. Each returned item is compared field by field under random
// stalls on both channels, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mass_spring_chain_derivative_top_test;
    import msc_pkg::*;

    typedef struct {
        logic [IdxW-1:0] idx;
        t_word           pos [3];
        t_word           vel [3];
        logic            last;
        logic            typed;
    } t_load;

    typedef struct {
        logic [IdxW-1:0] idx;
        t_word           dpos [3];
        t_word           acc [3];
        logic            last;
    } t_deriv;

    localparam int CycleLimit = 2000000;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [IdxW-1:0]   i_particle_index;
    logic signed [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic signed [31:0] i_vel_x, i_vel_y, i_vel_z;
    logic              i_last_particle;
    logic              o_valid;
    logic              i_ready;
    logic [IdxW-1:0]   o_out_index;
    logic signed [31:0] o_dpos_x, o_dpos_y, o_dpos_z;
    logic signed [31:0] o_accel_x, o_accel_y, o_accel_z;
    logic              o_last_result;
    logic              i_cfg_we;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0]       i_cfg_data;

    mass_spring_chain_derivative_top dut (.*);

    t_word        gravity_r;
    logic [30:0]  drag_r, rest_r, stiff_r;
    logic [3:0]   fixed_r;
    t_word        pos_mem [Particles][3];
    t_word        vel_mem [Particles][3];
    t_deriv       deriv_q [$];
    int           errors;
    int           cycles;
    int           accepted;
    logic         quiet_in, quiet_out;

    initial begin
        i_clk = 1'b0;
        forever begin
            #6 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("mass_spring_chain_derivative_top_test failed");
            $finish;
        end
    end

    function automatic t_word clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return t_word'(v);
    endfunction

    function automatic longint root64(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s = s - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Stores the item and, on a final item with queue_it set, queues the derivative of every particle.
    task automatic predict_chain(input t_load it, input logic queue_it);
        longint acc [Particles][3];
        longint d [3];
        logic [63:0] sq;
        longint len, mag, u, f, a;
        t_deriv r;
        for (int c = 0; c < 3; c++) begin
            pos_mem[it.idx][c] = it.pos[c];
            vel_mem[it.idx][c] = it.vel[c];
        end
        if (!it.last) return;
        for (int i = 0; i < Particles; i++) begin
            for (int c = 0; c < 3; c++) begin
                a = (c == 1) ? longint'(gravity_r) : 0;
                a = a - ((longint'(drag_r) * longint'(vel_mem[i][c])) >>> 16);
                acc[i][c] = clamp32(a);
            end
        end
        for (int i = 0; i + 1 < Particles; i++) begin
            sq = 0;
            for (int c = 0; c < 3; c++) begin
                d[c] = clamp32(longint'(pos_mem[i][c]) - longint'(pos_mem[i+1][c]));
                sq = sq + 64'(d[c] * d[c]);
            end
            len = root64(sq);
            if (len != 0) begin
                mag = (longint'(stiff_r) * (len - longint'(rest_r))) >>> 16;
                for (int c = 0; c < 3; c++) begin
                    u = (d[c] * 65536) / len;
                    f = (-(mag * u)) >>> 16;
                    acc[i][c] = clamp32(acc[i][c] + f);
                    acc[i+1][c] = clamp32(acc[i+1][c] - f);
                end
            end
        end
        if (!queue_it) return;
        for (int i = 0; i < Particles; i++) begin
            r.idx = IdxW'(i);
            for (int c = 0; c < 3; c++) begin
                r.dpos[c] = vel_mem[i][c];
                r.acc[c] = fixed_r[i] ? 32'sd0 : t_word'(acc[i][c]);
            end
            r.last = (i == Particles - 1);
            deriv_q.insert(deriv_q.size(), r);
        end
    endtask

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    function automatic int pick_gap(input logic quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GRAVITY: gravity_r = t_word'(data);
            CFG_DRAG:    drag_r = data[30:0];
            CFG_REST:    rest_r = data[30:0];
            CFG_STIFF:   stiff_r = data[30:0];
            CFG_MASK:    fixed_r = data[3:0];
            default: ;
        endcase
    endtask

    task automatic send_item(input t_load it);
        int gap;
        t_deriv e;
        gap = pick_gap(quiet_in);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_particle_index <= it.idx;
        i_pos_x <= it.pos[0];
        i_pos_y <= it.pos[1];
        i_pos_z <= it.pos[2];
        i_vel_x <= it.vel[0];
        i_vel_y <= it.vel[1];
        i_vel_z <= it.vel[2];
        i_last_particle <= it.last;
        do @(posedge i_clk); while (!o_ready);
        accepted++;
        if (it.typed) begin
            predict_chain(it, 1'b0);
            for (int i = 0; i < Particles; i++) begin
                e = '{idx: IdxW'(i), dpos: '{0, 0, 0},
                    acc: '{0, (i == 3) ? 32'sd0 : -32'sd131072, 0},
                    last: (i == Particles - 1)};
                deriv_q.insert(deriv_q.size(), e);
            end
        end else begin
            predict_chain(it, 1'b1);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (deriv_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3: return t_word'($urandom);
            default: return t_word'($urandom_range(0, 8 * 65536)) - 32'sd262144;
        endcase
    endfunction

    function automatic t_load rand_load(input logic [IdxW-1:0] idx, input logic last);
        t_load it;
        it.idx = idx;
        it.last = last;
        it.typed = 1'b0;
        for (int c = 0; c < 3; c++) begin
            it.pos[c] = rand_word();
            it.vel[c] = rand_word();
        end
        return it;
    endfunction

    function automatic logic [31:0] rand_reg(input int sel, input logic [31:0] lo,
                                             input logic [31:0] hi);
        if (sel == 0) return lo;
        if (sel == 1) return hi;
        if ($urandom_range(0, 1)) return $urandom & hi;
        return $urandom_range(0, 4 * 65536) + lo;
    endfunction

    localparam t_word Pmax = 32'sh7FFFFFFF;
    localparam t_word Pmin = 32'sh80000000;
    localparam t_word One = 32'sd65536;

    t_load plan [] = '{
        '{0, '{0, 0, 0}, '{0, 0, 0}, 0, 0},
        '{1, '{0, 0, 0}, '{0, 0, 0}, 0, 0},
        '{2, '{0, 0, 0}, '{0, 0, 0}, 0, 0},
        '{3, '{0, 0, 0}, '{0, 0, 0}, 1, 1},
        '{0, '{Pmax, Pmax, Pmax}, '{Pmax, Pmax, Pmax}, 0, 0},
        '{1, '{Pmin, Pmin, Pmin}, '{Pmin, Pmin, Pmin}, 0, 0},
        '{2, '{Pmax, Pmin, Pmax}, '{Pmin, Pmax, Pmin}, 0, 0},
        '{3, '{Pmin, Pmax, Pmin}, '{Pmax, Pmin, Pmax}, 1, 0},
        '{1, '{0, One, 0}, '{One, -One, 0}, 1, 0},
        '{0, '{One, 0, 0}, '{0, 0, 0}, 0, 0},
        '{1, '{One, 0, 0}, '{0, 0, 0}, 0, 0},
        '{2, '{2 * One, 0, 0}, '{0, 0, 0}, 0, 0},
        '{3, '{2 * One, 3 * One, 0}, '{-One, 0, One}, 1, 0},
        '{2, '{-5, 7, -9}, '{-1, 1, 0}, 0, 0},
        '{0, '{3, -3, 1}, '{1, -1, -1}, 1, 0}
    };

    initial begin
        int target;
        int n;
        int sel;
        logic [1:0] order [4];
        cycles = 0;
        errors = 0;
        accepted = 0;
        quiet_in = 1'b0;
        quiet_out = 1'b0;
        gravity_r = -32'sd131072;
        drag_r = 31'd65536;
        rest_r = 31'd65536;
        stiff_r = 31'd65536000;
        fixed_r = 4'd8;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_particle_index = '0;
        {i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z} = '0;
        i_last_particle = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (plan[k]) send_item(plan[k]);
        drain();
        for (int ph = 0; ph < 6; ph++) begin
            sel = (ph < 2) ? ph : 2;
            write_reg(CFG_GRAVITY, rand_reg(sel, 32'h80000000, 32'h7FFFFFFF));
            write_reg(CFG_DRAG, rand_reg(sel, 0, 32'h7FFFFFFF));
            write_reg(CFG_REST, rand_reg(sel, 0, 32'h7FFFFFFF));
            write_reg(CFG_STIFF, rand_reg(sel, 0, 32'h7FFFFFFF));
            write_reg(CFG_MASK, (sel == 0) ? 32'd0 : (sel == 1) ? 32'd15
                                           : 32'($urandom_range(0, 15)));
            quiet_in = (ph == 3);
            quiet_out = (ph == 4);
            target = accepted + 70;
            while (accepted < target) begin
                if ($urandom_range(0, 99) < 80) begin
                    order = '{0, 1, 2, 3};
                    if ($urandom_range(0, 1)) order.shuffle();
                    for (int k = 0; k < 4; k++) send_item(rand_load(order[k], k == 3));
                end else begin
                    n = $urandom_range(1, 3);
                    for (int k = 0; k < n; k++) begin
                        send_item(rand_load(IdxW'($urandom_range(0, 3)),
                                            (k == n - 1) && $urandom_range(0, 1)));
                    end
                end
            end
            drain();
        end
        if (errors == 0) begin
            $display("mass_spring_chain_derivative_top_test passed");
        end else begin
            $display("mass_spring_chain_derivative_top_test failed");
        end
        $finish;
    end

    initial begin
        t_deriv w;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (deriv_q.size() == 0) begin
                    report("unexpected item", o_out_index, -1);
                end else begin
                    w = deriv_q.pop_front();
                    if (o_out_index !== w.idx) report("out_index", o_out_index, w.idx);
                    if (o_dpos_x !== w.dpos[0]) report("dpos_x", o_dpos_x, w.dpos[0]);
                    if (o_dpos_y !== w.dpos[1]) report("dpos_y", o_dpos_y, w.dpos[1]);
                    if (o_dpos_z !== w.dpos[2]) report("dpos_z", o_dpos_z, w.dpos[2]);
                    if (o_accel_x !== w.acc[0]) report("accel_x", o_accel_x, w.acc[0]);
                    if (o_accel_y !== w.acc[1]) report("accel_y", o_accel_y, w.acc[1]);
                    if (o_accel_z !== w.acc[2]) report("accel_z", o_accel_z, w.acc[2]);
                    if (o_last_result !== w.last) report("last_result", o_last_result, w.last);
                end
            end
            i_ready <= (pick_gap(quiet_out) == 0);
        end
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/msc_pkg.sv
rtl/msc_cell.sv
rtl/msc_sqrt.sv
rtl/msc_div.sv
rtl/mass_spring_chain_derivative_top.sv
rtl/msc_checker.sv
tb/mass_spring_chain_derivative_top_test.sv
